@@ rtl/ism_pkg.sv @@
`default_nettype none

package ism_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int TOP_WIDTH   = 32;
    localparam int DEPTH_WIDTH = 11;
    localparam int CMD_WIDTH   = 4;
    localparam int DIGIT_WIDTH = 4;

    typedef logic [CMD_WIDTH-1:0]   cmd_t;
    typedef logic [DIGIT_WIDTH-1:0] digit_t;
    typedef logic [1:0]             status_t;

    localparam cmd_t CMD_LOAD   = 4'd0;
    localparam cmd_t CMD_ADD    = 4'd1;
    localparam cmd_t CMD_SUB    = 4'd2;
    localparam cmd_t CMD_MOD    = 4'd3;
    localparam cmd_t CMD_INC    = 4'd4;
    localparam cmd_t CMD_COPY   = 4'd5;
    localparam cmd_t CMD_DELETE = 4'd6;
    localparam cmd_t CMD_SWITCH = 4'd7;
    localparam cmd_t CMD_FINISH = 4'd8;

    localparam status_t ST_RUN   = 2'd0;
    localparam status_t ST_UNDER = 2'd1;
    localparam status_t ST_FAULT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } ism_state_t;

endpackage

`default_nettype wire

@@ rtl/ism_stack_ram.sv @@
`default_nettype none

module ism_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ism_mod_unit.sv @@
`default_nettype none

// truncated remainder, one restoring step per cycle
module ism_mod_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic      [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
            den_next = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
            neg_next = dividend[WIDTH-1];
        end
        else if (run_reg)
        begin
            rem_next = diff[WIDTH] ? shifted : diff;
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done      = done_reg;
    assign remainder = neg_reg ? (~rem_reg[WIDTH-1:0] + 1'b1) : rem_reg[WIDTH-1:0];

endmodule

`default_nettype wire

@@ rtl/integer_stack_machine_top.sv @@
// Integer stack machine, pre-decoded commands.
// Input channel (in_valid/in_ready): one beat carries command and digit.
// Output channel (out_valid/out_ready): one beat per command with the top
// entry (0 when empty), the depth, the halt status and, for finish, the
// finished and format_ok flags.
// The top entry lives in a register; entries below it sit in a simple
// dual-port RAM with registered read data. Mod runs through an iterative
// remainder unit, one restoring step per cycle.
// Load, copy, inc, finish, ignored commands and delete without a read go
// from accept straight to the done state; delete, add, sub and switch pass
// through the execute state; mod with a non-zero divisor goes on to the
// divide state. A new beat is taken once the previous command has placed
// its result in the output register.
// The output register parts the channels: a stalled receiver holds the
// result, and the next command still runs; its result waits until the
// output register is free.
// Reset empties the stack and clears the halt status; no clearing pass.
`default_nettype none

module integer_stack_machine_top #(
    parameter int STACK_DEPTH = ism_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = ism_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire ism_pkg::cmd_t                     command,
    input  wire ism_pkg::digit_t                   digit,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [ism_pkg::TOP_WIDTH-1:0]   top_value,
    output logic        [ism_pkg::DEPTH_WIDTH-1:0] stack_depth,
    output ism_pkg::status_t                       status,
    output logic                                   finished,
    output logic                                   format_ok
);

    import ism_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int W   = VALUE_WIDTH;

    ism_state_t     state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    status_t        halt_reg, halt_next;
    logic [W-1:0]   top_reg, top_next;
    cmd_t           cmd_reg, cmd_next;
    logic           fin_reg, fin_next;
    logic           out_valid_reg, out_valid_next;

    logic [TOP_WIDTH-1:0]   top_value_reg;
    logic [DEPTH_WIDTH-1:0] stack_depth_reg;
    status_t                status_reg;
    logic                   finished_reg;
    logic                   format_ok_reg;

    logic           in_fire;
    logic           out_load;
    logic [SPW-1:0] sp_dec1;
    logic [SPW-1:0] sp_dec2;
    logic           sp_full;
    logic           sp_ge2;
    logic           running;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [W-1:0]   wr_data;
    logic [W-1:0]   rd_data;
    logic           div_start;
    logic           div_done;
    logic [W-1:0]   div_rem;

    logic [W-1:0]             top_shown;
    logic [TOP_WIDTH+W-1:0]   top_ext;
    logic [DEPTH_WIDTH+SPW-1:0] sp_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign sp_dec1  = sp_reg - 1'b1;
    assign sp_dec2  = sp_reg - SPW'(2);
    assign sp_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign sp_ge2   = (sp_reg >= SPW'(2));
    assign running  = (halt_reg == ST_RUN);

    ism_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (sp_dec2[AW-1:0]),
        .rd_data (rd_data)
    );

    ism_mod_unit #(
        .WIDTH (W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (top_reg),
        .divisor   (rd_data),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_FINISH || !running)
                    begin
                        state_next = S_DONE;
                    end
                    else if (command inside {CMD_ADD, CMD_SUB, CMD_MOD, CMD_SWITCH, CMD_DELETE})
                    begin
                        state_next = sp_ge2 ? S_EXEC : S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_MOD && rd_data != '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sp_next        = sp_reg;
        halt_next      = halt_reg;
        top_next       = top_reg;
        cmd_next       = cmd_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_en          = 1'b0;
        wr_addr        = sp_dec1[AW-1:0];
        wr_data        = top_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = command;
                    fin_next = (command == CMD_FINISH);
                    if (command != CMD_FINISH && running)
                    begin
                        case (command)
                            CMD_LOAD:
                            begin
                                if (sp_full)
                                begin
                                    halt_next = ST_FAULT;
                                end
                                else
                                begin
                                    wr_en    = (sp_reg != '0);
                                    top_next = {{(W-DIGIT_WIDTH){1'b0}}, digit};
                                    sp_next  = sp_reg + 1'b1;
                                end
                            end
                            CMD_COPY:
                            begin
                                if (sp_full)
                                begin
                                    halt_next = ST_FAULT;
                                end
                                else if (sp_reg == '0)
                                begin
                                    top_next = '0;
                                    sp_next  = SPW'(1);
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    sp_next = sp_reg + 1'b1;
                                end
                            end
                            CMD_INC:
                            begin
                                if (sp_reg == '0)
                                begin
                                    top_next = '0;
                                    sp_next  = SPW'(1);
                                end
                                else
                                begin
                                    top_next = top_reg + 1'b1;
                                end
                            end
                            CMD_DELETE:
                            begin
                                if (sp_reg != '0)
                                begin
                                    sp_next = sp_dec1;
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MOD, CMD_SWITCH:
                            begin
                                if (!sp_ge2)
                                begin
                                    sp_next   = '0;
                                    halt_next = ST_UNDER;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_DELETE:
                    begin
                        top_next = rd_data;
                    end
                    CMD_SWITCH:
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = sp_dec2[AW-1:0];
                        top_next = rd_data;
                    end
                    CMD_ADD:
                    begin
                        top_next = top_reg + rd_data;
                        sp_next  = sp_dec1;
                    end
                    CMD_SUB:
                    begin
                        top_next = top_reg - rd_data;
                        sp_next  = sp_dec1;
                    end
                    CMD_MOD:
                    begin
                        if (rd_data == '0)
                        begin
                            halt_next = ST_FAULT;
                        end
                        else
                        begin
                            div_start = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    top_next = div_rem;
                    sp_next  = sp_dec1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (fin_reg)
                    begin
                        sp_next   = '0;
                        halt_next = ST_RUN;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            halt_reg      <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result snapshot, sign-extended or cut to the port width
    assign top_shown = (sp_reg == '0) ? '0 : top_reg;
    assign top_ext   = {{TOP_WIDTH{top_shown[W-1]}}, top_shown};
    assign sp_ext    = {{DEPTH_WIDTH{1'b0}}, sp_reg};

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        cmd_reg <= cmd_next;
        fin_reg <= fin_next;
        if (out_load)
        begin
            top_value_reg   <= top_ext[TOP_WIDTH-1:0];
            stack_depth_reg <= sp_ext[DEPTH_WIDTH-1:0];
            status_reg      <= halt_reg;
            finished_reg    <= fin_reg;
            format_ok_reg   <= fin_reg && running && (sp_reg == SPW'(1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign stack_depth = stack_depth_reg;
    assign status      = status_reg;
    assign finished    = finished_reg;
    assign format_ok   = format_ok_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && fin_reg) |=> (sp_reg == '0 && halt_reg == ST_RUN))
        else $error("finish did not clear the machine");

    a_halted_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !running) |=> ($stable(sp_reg) && $stable(top_reg)))
        else $error("halted machine changed its stack");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder unit finished outside its state");

endmodule

`default_nettype wire
